// ===== rtl/vfc_pkg.sv =====
`timescale 1ns / 1ps
package vfc_pkg;
   localparam int FRAC_BITS = 16;
   localparam int WORD_W    = 32;

   typedef enum logic [2:0] {
      OP_LOAD    = 3'd0,
      OP_EXTRACT = 3'd1,
      OP_BOX     = 3'd2,
      OP_SPHERE  = 3'd3,
      OP_POINT   = 3'd4
   } op_type;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      if (v > 34'sd2147483647) return 32'sh7fffffff;
      else if (v < -34'sd2147483648) return 32'sh80000000;
      else return v[31:0];
   endfunction
endpackage

// ===== rtl/vfc_ram.sv =====
`timescale 1ns / 1ps
module vfc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/view_frustum_culler.sv =====
`timescale 1ns / 1ps
// Frustum culler. Matrix elements (column-major) are written by load transfers;
// extract derives the six clip planes (left, right, bottom, top, near, far)
// and normalizes each to unit length; box, sphere and point tests return one
// visible bit each. Matrix and planes live in two one-port-read RAMs that
// reset clears with a sweep before the first transfer is taken. A test reads
// up to 24 plane words with one 32x32 multiplier, each word passing read,
// multiply and accumulate steps, and stops at the first plane that culls; the
// next transfer can be taken in the cycle after the result is loaded.
// Extract reads 48 matrix words and runs, per plane, a 32-step square root and
// four 48-step restoring divides; a zero-length plane skips the divides and
// is stored unnormalized. A load writes its element as the transfer is taken.
// Results wait in an output register; a waiting result holds off only the next
// result, not the next transfer.
module view_frustum_culler
   import vfc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // op[2:0], element_index[6:3], element_value[38:7], a_x[70:39], a_y[102:71],
   // a_z[134:103], b_x[166:135], b_y[198:167], b_z[230:199],
   // sphere_radius[261:231], zero fill to 264
   input  logic [263:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // visible[0], zero fill
   output logic [7:0]   rsp_tdata
);
   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_MRD, S_MCAP, S_LEN, S_DIV, S_PWR,
      S_TRD, S_TMUL, S_TACC, S_RESP
   } state_type;

   state_type state_ff;
   logic [4:0] cnt_ff;          // clear counter
   logic [2:0] plane_ff;
   logic [1:0] k_ff;
   logic       half_ff;
   logic [2:0] op_ff;
   logic signed [31:0] ax_ff, ay_ff, az_ff, bx_ff, by_ff, bz_ff;
   logic [30:0] rad_ff;
   logic signed [31:0] c_ff [4];
   logic signed [31:0] w_ff;
   logic signed [63:0] prod_ff;
   logic signed [65:0] acc_ff;
   logic [63:0] sq_ff;
   logic [63:0] rem_ff, root_ff, bit_ff;
   logic [31:0] len_ff;
   logic [47:0] dvd_ff, quo_ff;
   logic [48:0] drem_ff;
   logic [5:0]  step_ff;
   logic        vis_ff;
   logic        rsp_valid_ff;
   logic        rsp_vis_ff;

   logic [2:0]  op_in;
   assign op_in = req_tdata[2:0];

   // RAM ports
   logic        m_we;
   logic [3:0]  m_wa, m_ra;
   logic [31:0] m_wd, m_rd;
   logic        p_we;
   logic [4:0]  p_wa, p_ra;
   logic [31:0] p_wd, p_rd;

   vfc_ram #(.WIDTH(32), .DEPTH(16)) u_mat (
      .clock, .wr_en(m_we), .wr_addr(m_wa), .wr_data(m_wd),
      .rd_addr(m_ra), .rd_data(m_rd));
   vfc_ram #(.WIDTH(32), .DEPTH(24)) u_pln (
      .clock, .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd),
      .rd_addr(p_ra), .rd_data(p_rd));

   // result register loads in S_RESP when empty or being drained
   logic rsp_load;
   assign rsp_load = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_tready);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_vis_ff};

   logic accept;
   assign accept = req_tvalid && req_tready;

   // matrix address: column k, row half? row3 : plane row
   logic [1:0] mrow;
   assign mrow = half_ff ? 2'd3 : 2'(plane_ff >> 1);
   assign m_ra = {k_ff, mrow};
   assign p_ra = 5'({plane_ff, k_ff});

   always_comb begin
      m_we = 1'b0; m_wa = req_tdata[6:3]; m_wd = req_tdata[38:7];
      if (state_ff == S_CLEAR) begin
         m_we = 1'b1; m_wa = cnt_ff[3:0]; m_wd = '0;
      end else if (accept && op_in == OP_LOAD) m_we = 1'b1;
   end

   // normalized component select
   logic signed [31:0] cur_c;
   assign cur_c = c_ff[k_ff];

   always_comb begin
      p_we = 1'b0; p_wa = 5'({plane_ff, k_ff}); p_wd = cur_c;
      if (state_ff == S_CLEAR) begin
         p_we = 1'b1; p_wa = cnt_ff; p_wd = '0;
      end else if (state_ff == S_PWR) p_we = 1'b1;
   end

   // test helpers
   logic signed [31:0] coord;
   always_comb begin
      unique case (k_ff)
         2'd0: coord = (op_ff == OP_BOX && !p_rd[31]) ? bx_ff : ax_ff;
         2'd1: coord = (op_ff == OP_BOX && !p_rd[31]) ? by_ff : ay_ff;
         default: coord = (op_ff == OP_BOX && !p_rd[31]) ? bz_ff : az_ff;
      endcase
   end

   logic signed [33:0] comb_sum;
   always_comb begin
      if (plane_ff[0]) comb_sum = 34'(signed'(m_rd)) - 34'(signed'(c_ff[k_ff]));
      else comb_sum = 34'(signed'(m_rd)) + 34'(signed'(c_ff[k_ff]));
   end

   logic [63:0] isq_try;
   assign isq_try = root_ff + bit_ff;
   logic [48:0] dtry;
   assign dtry = {drem_ff[47:0], dvd_ff[47]};
   logic [48:0] dsub;
   assign dsub = dtry - {17'd0, len_ff};

   logic signed [65:0] dist_limit;
   assign dist_limit = (op_ff == OP_SPHERE) ? -66'(signed'({1'b0, rad_ff})) : 66'sd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_vis_ff <= 1'b0;
         vis_ff <= 1'b1;
         plane_ff <= '0; k_ff <= '0; half_ff <= 1'b0; step_ff <= '0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_vis_ff <= vis_ff;
         end else if (rsp_tready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd23) state_ff <= S_IDLE;
            end
            S_IDLE: if (accept) begin
               op_ff <= op_in;
               ax_ff <= req_tdata[70:39];  ay_ff <= req_tdata[102:71];
               az_ff <= req_tdata[134:103]; bx_ff <= req_tdata[166:135];
               by_ff <= req_tdata[198:167]; bz_ff <= req_tdata[230:199];
               rad_ff <= req_tdata[261:231];
               plane_ff <= '0; k_ff <= '0; half_ff <= 1'b0;
               vis_ff <= 1'b1;
               if (op_in == OP_EXTRACT) state_ff <= S_MRD;
               else if (op_in == OP_BOX || op_in == OP_SPHERE || op_in == OP_POINT) begin
                  acc_ff <= '0;
                  state_ff <= S_TRD;
               end
            end
            // extract: read row word (half 0) into c, then row 3 (half 1) combine
            S_MRD: state_ff <= S_MCAP;
            S_MCAP: begin
               if (!half_ff) begin
                  c_ff[k_ff] <= m_rd;
                  half_ff <= 1'b1;
                  state_ff <= S_MRD;
               end else begin
                  c_ff[k_ff] <= sat32(comb_sum);
                  half_ff <= 1'b0;
                  k_ff <= k_ff + 2'd1;
                  if (k_ff == 2'd3) begin
                     sq_ff <= '0; step_ff <= '0;
                     state_ff <= S_LEN;
                  end else state_ff <= S_MRD;
               end
            end
            // steps 0..2 square sum, 3 init root, 4.. root iterations
            S_LEN: begin
               if (step_ff < 6'd3) begin
                  step_ff <= step_ff + 6'd1;
                  prod_ff <= c_ff[step_ff[1:0]] * c_ff[step_ff[1:0]];
                  if (step_ff != 6'd0) sq_ff <= sq_ff + 64'(prod_ff);
               end else if (step_ff == 6'd3) begin
                  step_ff <= step_ff + 6'd1;
                  sq_ff <= sq_ff + 64'(prod_ff);
                  rem_ff <= sq_ff + 64'(prod_ff);
                  root_ff <= '0;
                  bit_ff <= 64'd1 << 62;
               end else begin
                  if (bit_ff == 64'd0) begin
                     len_ff <= root_ff[31:0];
                     k_ff <= '0;
                     if (sq_ff == 64'd0) state_ff <= S_PWR;
                     else begin
                        dvd_ff <= (cur_c[31] ? 48'(-49'(signed'(cur_c)))
                                             : 48'(cur_c)) << FRAC_BITS;
                        drem_ff <= '0; quo_ff <= '0; step_ff <= '0;
                        state_ff <= S_DIV;
                     end
                  end else begin
                     step_ff <= step_ff + 6'd1;
                     if (rem_ff >= isq_try) begin
                        rem_ff <= rem_ff - isq_try;
                        root_ff <= (root_ff >> 1) + bit_ff;
                     end else root_ff <= root_ff >> 1;
                     bit_ff <= bit_ff >> 2;
                  end
               end
            end
            S_DIV: begin
               if (step_ff == 6'd48) begin
                  if (cur_c[31])
                     c_ff[k_ff] <= (quo_ff > 48'h80000000) ? 32'sh80000000
                                   : 32'(-quo_ff);
                  else
                     c_ff[k_ff] <= (quo_ff > 48'h7fffffff) ? 32'sh7fffffff
                                   : quo_ff[31:0];
                  // after finishing a component, reload for the next one
                  step_ff <= (k_ff == 2'd3) ? 6'd0 : 6'd49;
                  if (k_ff == 2'd3) begin
                     k_ff <= '0;
                     state_ff <= S_PWR;
                  end else k_ff <= k_ff + 2'd1;
               end else if (step_ff == 6'd49) begin
                  dvd_ff <= (cur_c[31] ? 48'(-49'(signed'(cur_c)))
                                       : 48'(cur_c)) << FRAC_BITS;
                  drem_ff <= '0; quo_ff <= '0; step_ff <= '0;
               end else begin
                  dvd_ff <= dvd_ff << 1;
                  if (!dsub[48]) begin
                     drem_ff <= dsub; quo_ff <= {quo_ff[46:0], 1'b1};
                  end else begin
                     drem_ff <= dtry; quo_ff <= {quo_ff[46:0], 1'b0};
                  end
                  step_ff <= step_ff + 6'd1;
               end
            end
            S_PWR: begin
               k_ff <= k_ff + 2'd1;
               if (k_ff == 2'd3) begin
                  if (plane_ff == 3'd5) state_ff <= S_IDLE;
                  else begin
                     plane_ff <= plane_ff + 3'd1;
                     state_ff <= S_MRD;
                  end
               end
            end
            // test: read word, multiply, accumulate
            S_TRD: state_ff <= S_TMUL;
            S_TMUL: begin
               if (k_ff == 2'd3) begin
                  prod_ff <= 64'(signed'(p_rd)) <<< FRAC_BITS;
               end else prod_ff <= signed'(p_rd) * coord;
               state_ff <= S_TACC;
            end
            S_TACC: begin
               if (k_ff == 2'd3) begin
                  if (acc_ff + 66'(prod_ff >>> FRAC_BITS) < dist_limit) begin
                     vis_ff <= 1'b0;
                     state_ff <= S_RESP;
                  end else if (plane_ff == 3'd5) state_ff <= S_RESP;
                  else begin
                     plane_ff <= plane_ff + 3'd1;
                     acc_ff <= '0;
                     state_ff <= S_TRD;
                  end
                  k_ff <= '0;
               end else begin
                  acc_ff <= acc_ff + 66'(prod_ff >>> FRAC_BITS);
                  k_ff <= k_ff + 2'd1;
                  state_ff <= S_TRD;
               end
            end
            S_RESP: begin
               if (rsp_load) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_resp_only_after_test: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_RESP)
      else $error("response without test");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |-> state_ff == S_IDLE)
      else $error("accept while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff && $stable(rsp_vis_ff))
      else $error("waiting response changed");
   a_no_write_in_test: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TRD || state_ff == S_TMUL || state_ff == S_TACC) |-> !p_we && !m_we)
      else $error("store written during test");
endmodule

// ===== tb/sv/view_frustum_culler_tb.sv =====
`timescale 1ns / 1ps
module view_frustum_culler_tb;
   import vfc_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [263:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [7:0]   rsp_tdata;

   view_frustum_culler i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #1 clock = ~clock;

   // predictor state
   logic signed [31:0] mat_words [16];
   logic signed [31:0] plane_words [24];
   logic               visible_queue [$];
   int                 error_count = 0;
   int                 vis_seen = 0;
   int                 hold_left = 0;
   bit                 stall_busy = 1'b1;

   task automatic report_mismatch(input string what);
      error_count++;
      $display("ERROR %0t: %s", $realtime, what);
   endtask

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic longint unsigned root64(input longint unsigned v);
      longint unsigned r = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic void build_planes();
      longint c [4];
      longint unsigned sq, len, mag, q;
      int row;
      for (int p = 0; p < 6; p++) begin
         row = p >> 1;
         sq = 0;
         for (int k = 0; k < 4; k++) begin
            if (p & 1) c[k] = longint'(mat_words[k*4+3]) - longint'(mat_words[k*4+row]);
            else c[k] = longint'(mat_words[k*4+3]) + longint'(mat_words[k*4+row]);
            c[k] = clamp32(c[k]);
         end
         for (int k = 0; k < 3; k++) sq += unsigned'(c[k] * c[k]);
         if (sq != 0) begin
            len = root64(sq);
            for (int k = 0; k < 4; k++) begin
               mag = (c[k] < 0) ? unsigned'(-c[k]) : unsigned'(c[k]);
               q = (mag << FRAC_BITS) / len;
               if (c[k] < 0) begin
                  if (q > 64'd2147483648) q = 64'd2147483648;
                  c[k] = -longint'(q);
               end else begin
                  if (q > 64'd2147483647) q = 64'd2147483647;
                  c[k] = longint'(q);
               end
            end
         end
         for (int k = 0; k < 4; k++) plane_words[p*4+k] = c[k][31:0];
      end
   endfunction

   function automatic logic cull_test(input op_type op, input logic [31:0] a [3],
                                      input logic [31:0] b [3],
                                      input logic [30:0] radius);
      longint d;
      logic signed [31:0] v;
      for (int p = 0; p < 6; p++) begin
         d = plane_words[p*4+3];
         for (int k = 0; k < 3; k++) begin
            v = (op == OP_BOX && plane_words[p*4+k] >= 0) ? signed'(b[k]) : signed'(a[k]);
            d += (longint'(plane_words[p*4+k]) * longint'(v)) >>> FRAC_BITS;
         end
         if (op == OP_SPHERE) begin
            if (d < -longint'(radius)) return 1'b0;
         end else if (d < 0) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic int gap_len();
      int r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   task automatic send_item(input logic [2:0] op, input logic [3:0] idx,
                            input logic [31:0] val, input logic [31:0] a [3],
                            input logic [31:0] b [3], input logic [30:0] radius);
      int g = gap_len();
      repeat (g) @(negedge clock);
      req_tdata <= {2'b0, radius, b[2], b[1], b[0], a[2], a[1], a[0], val, idx, op};
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      case (op)
         OP_LOAD:    mat_words[idx] = val;
         OP_EXTRACT: build_planes();
         OP_BOX, OP_SPHERE, OP_POINT:
            visible_queue.push_back(cull_test(op_type'(op), a, b, radius));
         default: ;
      endcase
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (visible_queue.size() == 0) begin
            report_mismatch("result with no expectation");
         end else begin
            logic e;
            e = visible_queue.pop_front();
            vis_seen++;
            if (rsp_tdata[0] !== e)
               report_mismatch($sformatf("visible got %b exp %b", rsp_tdata[0], e));
            if (rsp_tdata[7:1] !== 7'd0) report_mismatch("nonzero fill bits");
         end
      end
   end

   // always ready while stall_busy is set; then mostly short back-pressure, now and then a long hold
   always @(negedge clock) begin
      if (stall_busy) rsp_tready <= 1'b1;
      else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < 4) begin
         hold_left = $urandom_range(5, 40);
         rsp_tready <= 1'b0;
      end else rsp_tready <= ($urandom_range(0, 99) < 70);
   end

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom_range(0, 32'h3ffff) - 32'h1ffff;
         3: return {{15{1'b0}}, 1'b1, 16'h0} * $urandom_range(0, 4);
         4: return -($urandom_range(0, 4) << 16);
         default: return $urandom;
      endcase
   endfunction

   task automatic wait_drained();
      while (visible_queue.size() != 0) @(negedge clock);
   endtask

   task automatic load_matrix(input logic [31:0] m [16]);
      logic [31:0] z [3] = '{0, 0, 0};
      for (int i = 0; i < 16; i++) send_item(OP_LOAD, i[3:0], m[i], z, z, 31'd0);
   endtask

   task automatic send_test(input logic [2:0] op, input logic [31:0] a [3],
                            input logic [31:0] b [3], input logic [30:0] r);
      send_item(op, 4'd0, 32'd0, a, b, r);
   endtask

   task automatic test_before_extract();
      logic [31:0] a [3] = '{32'h80000000, 32'h7fffffff, 0};
      logic [31:0] b [3] = '{32'h7fffffff, 32'h80000000, 32'hffffffff};
      send_test(OP_BOX, a, b, 31'd0);
      send_test(OP_SPHERE, a, b, 31'h7fffffff);
      send_test(OP_POINT, b, a, 31'd0);
      send_item(3'd5, 4'hf, 32'hffffffff, a, b, 31'h7fffffff);
      send_item(3'd7, 4'h0, 32'h0, a, b, 31'd0);
   endtask

   task automatic test_identity();
      logic [31:0] m [16];
      logic [31:0] a [3], b [3];
      for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? 32'h10000 : 32'h0;
      load_matrix(m);
      a = '{0, 0, 0};
      send_item(OP_EXTRACT, 4'd0, 32'd0, a, a, 31'd0);
      send_test(OP_POINT, a, a, 31'd0);
      a = '{32'h20000, 0, 0};
      send_test(OP_POINT, a, a, 31'd0);
      a = '{32'h30000, 32'h30000, 32'h30000};
      b = '{32'h40000, 32'h40000, 32'h40000};
      send_test(OP_BOX, a, b, 31'd0);
      send_test(OP_SPHERE, a, a, 31'h30000);
      send_test(OP_SPHERE, a, a, 31'h0);
   endtask

   task automatic test_saturation();
      logic [31:0] m [16];
      logic [31:0] a [3] = '{32'h7fffffff, 32'h80000000, 32'h7fffffff};
      for (int i = 0; i < 16; i++) m[i] = (i & 1) ? 32'h80000000 : 32'h7fffffff;
      m[3] = 0; m[7] = 0; m[11] = 0; // row 3 of xyz zero on some planes
      load_matrix(m);
      send_item(OP_EXTRACT, 4'd0, 32'd0, a, a, 31'd0);
      send_test(OP_POINT, a, a, 31'd0);
      send_test(OP_BOX, a, a, 31'd0);
   endtask

   task automatic test_random(input int n);
      logic [31:0] a [3], b [3];
      int kind;
      for (int i = 0; i < n; i++) begin
         kind = $urandom_range(0, 99);
         for (int k = 0; k < 3; k++) begin
            a[k] = rand_word();
            b[k] = rand_word();
         end
         if (kind < 12)
            send_item(OP_LOAD, 4'($urandom_range(0, 15)), rand_word(), a, b, 31'd0);
         else if (kind < 14)
            send_item(OP_EXTRACT, 4'($urandom), $urandom, a, b, 31'($urandom));
         else if (kind < 16)
            send_item(3'($urandom_range(5, 7)), 4'($urandom), $urandom, a, b,
                      31'($urandom));
         else if (kind < 44) send_test(OP_BOX, a, b, 31'($urandom));
         else if (kind < 72)
            send_test(OP_SPHERE, a, b,
                      31'(($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 31'h80000)));
         else send_test(OP_POINT, a, b, 31'($urandom));
         if (i == n / 2) wait_drained();
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_before_extract();
      test_identity();
      test_saturation();
      stall_busy = 1'b0;
      test_random(1000);
      wait_drained();
      repeat (60) @(negedge clock);
      if (error_count == 0 && visible_queue.size() == 0) begin
         $display("PASS view_frustum_culler");
      end else begin
         $display("FAIL view_frustum_culler");
      end
      $finish;
   end

   // timeout for about 25 extracts plus about 1000 tests with stalls
   initial begin
      #2000000;
      $display("FAIL view_frustum_culler");
      $finish;
   end
endmodule

// ===== view_frustum_culler.f =====
rtl/vfc_pkg.sv
rtl/vfc_ram.sv
rtl/view_frustum_culler.sv
tb/sv/view_frustum_culler_tb.sv
